// ----- sv/aes128_block_encrypt_macros.svh -----
// Assertion macros shared by the AES-128 encryption block.
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define AES_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define AES_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/aes_pkg.sv -----
// Package with AES-128 types, tables and round functions.
`timescale 1ns / 1ps
package aes_pkg;

   localparam int unsigned NumRounds = 10;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;

   function automatic byte_type sbox(input byte_type a);
      byte_type r;
      unique case (a)
         8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
         8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
         8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
         8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
         8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
         8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
         8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
         8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
         8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
         8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
         8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
         8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
         8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
         8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
         8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
         8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
         8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
         8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
         8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
         8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
         8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
         8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
         8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
         8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
         8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
         8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
         8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
         8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
         8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
         8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
         8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
         8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
         8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
         8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
         8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
         8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
         8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
         8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
         8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
         8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
         8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
         8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
         8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
         8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
         8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
         8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
         8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
         8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
         8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
         8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
         8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
         8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
         8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
         8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
         8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
         8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
         8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
         8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
         8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
         8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
         8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
         8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
         8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
         8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // Round constant for round key n, n from 1 to 10.
   function automatic byte_type rcon(input logic [3:0] n);
      byte_type r;
      unique case (n)
         4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
         4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
         4'd9: r = 8'h1b; 4'd10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type gf_double(input byte_type b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte k of the block sits in bits 127-8k downto 120-8k.
   function automatic byte_type get_byte(input block_type s, input int unsigned k);
      return s[127 - 8 * k -: 8];
   endfunction

   // Next round key from the previous one.
   function automatic block_type next_key(input block_type k, input logic [3:0] n);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rcon(n), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] = sbox(get_byte(s, 4 * ((c + r) % 4) + r));
         end
      end
      return t;
   endfunction

   function automatic block_type mix_columns(input block_type s);
      block_type t;
      byte_type a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4 * c);
         a1 = get_byte(s, 4 * c + 1);
         a2 = get_byte(s, 4 * c + 2);
         a3 = get_byte(s, 4 * c + 3);
         al = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32 * c -: 8] = a0 ^ al ^ gf_double(a0 ^ a1);
         t[119 - 32 * c -: 8] = a1 ^ al ^ gf_double(a1 ^ a2);
         t[111 - 32 * c -: 8] = a2 ^ al ^ gf_double(a2 ^ a3);
         t[103 - 32 * c -: 8] = a3 ^ al ^ gf_double(a3 ^ a0);
      end
      return t;
   endfunction

endpackage

// ----- sv/aes_round.sv -----
// One registered AES round stage with on-the-fly key expansion.
`timescale 1ns / 1ps
module aes_round
   import aes_pkg::*;
#(
   parameter logic [3:0] RoundNum = 4'd1
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  block_type in_state,
   input  block_type in_key,
   output logic      out_valid,
   output block_type out_state,
   output block_type out_key
);

   logic      valid_ff;
   block_type state_ff, key_ff;
   block_type state_in, key_in, mixed;

   always_comb begin
      key_in = next_key(in_key, RoundNum);
      mixed = (RoundNum == 4'(NumRounds)) ? sub_shift(in_state)
                                           : mix_columns(sub_shift(in_state));
      state_in = mixed ^ key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         state_ff <= state_in;
         key_ff <= key_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_key = key_ff;

endmodule

// ----- sv/aes128_block_encrypt.sv -----
// Pipeline: eleven register stages between an accepted request and rsp_valid
// (one stage for the initial key add, then one stage per round).
// Throughput: one block per cycle; each round stage holds a registered
// S-box round and its key expansion step, and the whole pipe holds on stall.
// Reset empties the pipeline and clears both key registers to zero.
`timescale 1ns / 1ps
module aes128_block_encrypt
   import aes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_text_high,
   input  logic [63:0] req_text_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);
`include "aes128_block_encrypt_macros.svh"

   localparam logic CsrKeyHigh = 1'b0;
   localparam logic CsrKeyLow  = 1'b1;

   logic [63:0] key_high_ff, key_low_ff;
   logic        advance;
   logic        v0_ff;
   block_type   s0_ff, k0_ff;
   logic      [NumRounds:0] vld;
   block_type stt [NumRounds+1];
   block_type kys [NumRounds+1];

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
         v0_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CsrKeyHigh: key_high_ff <= csr_data;
               CsrKeyLow:  key_low_ff <= csr_data;
               default: ;
            endcase
         end
         if (advance) begin
            v0_ff <= req_valid;
         end
      end
      if (advance) begin
         s0_ff <= {req_text_high, req_text_low} ^ {key_high_ff, key_low_ff};
         k0_ff <= {key_high_ff, key_low_ff};
      end
   end

   assign vld[0] = v0_ff;
   assign stt[0] = s0_ff;
   assign kys[0] = k0_ff;

   for (genvar g = 1; g <= NumRounds; g++) begin : g_round
      aes_round #(.RoundNum(4'(g))) u_round (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (vld[g-1]),
         .in_state (stt[g-1]),
         .in_key   (kys[g-1]),
         .out_valid(vld[g]),
         .out_state(stt[g]),
         .out_key  (kys[g])
      );
   end

   assign rsp_valid = vld[NumRounds];
   assign rsp_cipher_high = stt[NumRounds][127:64];
   assign rsp_cipher_low = stt[NumRounds][63:0];

   `AES_ASSERT_IMP(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall,
      "input not stalled while output is held")
   `AES_ASSERT_NEXT(a_hold_out, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_cipher_high) && $stable(rsp_cipher_low),
      "held result changed")
   `AES_ASSERT_NEXT(a_first_stage, clock, reset, req_valid && !req_stall, v0_ff,
      "accepted request missing from first stage")

endmodule

// ----- test/aes128_encrypt_checker.sv -----
// Checker that predicts AES-128 ciphertexts and compares them with the block's responses.
`timescale 1ns / 1ps
module aes128_encrypt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_text_high,
   input  logic [63:0] req_text_low,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_cipher_high,
   input  logic [63:0] rsp_cipher_low,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_data,
   output int          errors,
   output int          outstanding
);

   localparam logic KeyHighIndex = 1'b0;
   localparam logic KeyLowIndex  = 1'b1;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } cipher_type;

   logic [7:0]  subst [256];
   logic [63:0] key_high_copy;
   logic [63:0] key_low_copy;
   cipher_type  cipher_expect [$];

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ a;
         a = xtime(a);
      end
      return p;
   endfunction

   // The substitution table is built from the field inverse and the affine map.
   initial begin
      logic [7:0] inv, v;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++) begin
            if (x != 0 && field_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         end
         v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         subst[x] = v;
      end
   end

   function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                  input logic [127:0] text);
      logic [127:0] st, tmp, rk;
      logic [31:0]  w;
      logic [7:0]   rc, a0, a1, a2, a3, al;
      rc = 8'h01;
      rk = key;
      st = text ^ key;
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               tmp[127 - 8 * (4 * c + r) -: 8] =
                  subst[st[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
         end
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = tmp[127 - 32 * c -: 8];
               a1 = tmp[119 - 32 * c -: 8];
               a2 = tmp[111 - 32 * c -: 8];
               a3 = tmp[103 - 32 * c -: 8];
               al = a0 ^ a1 ^ a2 ^ a3;
               tmp[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
               tmp[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
               tmp[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
               tmp[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end
         end
         w = {subst[rk[23:16]] ^ rc, subst[rk[15:8]], subst[rk[7:0]], subst[rk[31:24]]};
         rk[127:96] = rk[127:96] ^ w;
         rk[95:64]  = rk[95:64] ^ rk[127:96];
         rk[63:32]  = rk[63:32] ^ rk[95:64];
         rk[31:0]   = rk[31:0] ^ rk[63:32];
         rc = xtime(rc);
         st = tmp ^ rk;
      end
      return st;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
      errors++;
   endtask

   assign outstanding = cipher_expect.size();

   always @(posedge clock) begin
      cipher_type want;
      if (reset) begin
         errors = 0;
         key_high_copy = '0;
         key_low_copy = '0;
         cipher_expect.delete();
      end else begin
         if (req_valid && !req_stall) begin
            cipher_expect.push_back(encrypt_block({key_high_copy, key_low_copy},
                                                  {req_text_high, req_text_low}));
         end
         if (rsp_valid && !rsp_stall) begin
            if (cipher_expect.size() == 0) begin
               $display("unexpected response at %0t: %h %h", $time,
                        rsp_cipher_high, rsp_cipher_low);
               errors++;
            end else begin
               want = cipher_expect.pop_front();
               if (rsp_cipher_high !== want.high)
                  report_mismatch("cipher_high", rsp_cipher_high, want.high);
               if (rsp_cipher_low !== want.low)
                  report_mismatch("cipher_low", rsp_cipher_low, want.low);
            end
         end
         if (csr_write) begin
            if (csr_index == KeyHighIndex) key_high_copy = csr_data;
            else if (csr_index == KeyLowIndex) key_low_copy = csr_data;
         end
      end
   end

endmodule

// ----- test/tb_aes128_block_encrypt.sv -----
// Testbench top that drives AES-128 requests, keys and stalls and gives the verdict.
`timescale 1ns / 1ps
module tb_aes128_block_encrypt;

   localparam logic KeyHighIndex = 1'b0;
   localparam logic KeyLowIndex  = 1'b1;
   localparam int   CycleLimit   = 600000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_text_high;
   logic [63:0] req_text_low;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic        csr_write;
   logic        csr_index;
   logic [63:0] csr_data;
   int          errors;
   int          outstanding;
   int          cycles;
   bit          stall_enable;

   aes128_block_encrypt dut (.*);

   aes128_encrypt_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 5))
         0: return 64'd1 << $urandom_range(0, 63);
         1: return ~(64'd1 << $urandom_range(0, 63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_request(input logic [63:0] hi, input logic [63:0] lo);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_high <= hi;
      req_text_low <= lo;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      @(posedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
      csr_write <= 1'b1;
      csr_index <= KeyHighIndex;
      csr_data <= hi;
      @(posedge clock);
      csr_index <= KeyLowIndex;
      csr_data <= lo;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Response-side stalls come in stretches; some stretches have none at all.
   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0) stall_enable <= ~stall_enable;
      if (!stall_enable) rsp_stall <= 1'b0;
      else if (rsp_stall) rsp_stall <= ($urandom_range(0, 99) < 85);
      else rsp_stall <= ($urandom_range(0, 99) < 20);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb_aes128_block_encrypt: done, errors");
         $finish;
      end
   end

   initial begin
      cycles = 0;
      stall_enable = 1'b1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_text_high = '0;
      req_text_low = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = KeyHighIndex;
      csr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The key is zero after reset.
      send_request('0, '0);
      send_request('1, '1);
      send_request(64'h0011223344556677, 64'h8899aabbccddeeff);
      drain();

      write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_request(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_request('0, '1);
      send_request('1, '0);
      drain();

      write_key('1, '1);
      send_request('0, '0);
      send_request('1, '1);
      send_request(64'h8000000000000000, 64'h0000000000000001);
      drain();

      write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
      send_request(64'h3243f6a8885a308d, 64'h313198a2e0370734);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_key('0, '1);
            1: write_key('1, '0);
            default: write_key(random_word(), random_word());
         endcase
         for (int i = 0; i < 200; i++) send_request(random_word(), random_word());
         drain();
      end

      if (errors == 0) begin
         $display("tb_aes128_block_encrypt: done, clean");
      end else begin
         $display("tb_aes128_block_encrypt: done, errors");
      end
      $finish;
   end

endmodule
